@@ hw/rtl/protected_id_access_filter_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the protected identifier access filter
// Clocked on clk_i, disabled while rst_ni is low; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef PROTECTED_ID_ACCESS_FILTER_UNIT_ASSERT_SVH
`define PROTECTED_ID_ACCESS_FILTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PIDAF_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pidaf assertion failed");
// next-cycle implication
`define PIDAF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pidaf assertion failed");
`else
`define PIDAF_ASSERT(lbl, ante, cons)
`define PIDAF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/pidaf_pkg.sv @@
// ---------------------------------------------------------------------------
// pidaf_pkg
// Shared constants, codes and structs of the protected identifier filter.
// ---------------------------------------------------------------------------
package pidaf_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned ID_W        = 32;
  localparam int unsigned MASK_W      = 32;
  localparam int unsigned CFG_IDX_W   = 2;

  // request and event codes
  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_EXIT   = 2'd1,
    OP_PROC   = 2'd2,
    OP_THREAD = 2'd3
  } op_e;

  // table outcome codes
  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROC_DANGER = 2'd0,
    CFG_THR_DANGER  = 2'd1,
    CFG_PROC_FULL   = 2'd2,
    CFG_THR_FULL    = 2'd3
  } cfg_idx_e;

  localparam logic [MASK_W-1:0] FULL_ACCESS_RST = 32'h001F_FFFF;

  typedef struct packed {
    logic [MASK_W-1:0] proc_danger;
    logic [MASK_W-1:0] thr_danger;
    logic [MASK_W-1:0] proc_full;
    logic [MASK_W-1:0] thr_full;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic              path_match;
    logic [ID_W-1:0]   subject_id;
    logic [ID_W-1:0]   caller_id;
    logic [ID_W-1:0]   target_id;
    logic              target_missing;
    logic              kernel_handle;
    logic              handle_kind;
    logic [MASK_W-1:0] desired_access;
  } req_t;

  typedef struct packed {
    logic [MASK_W-1:0] granted_access;
    logic              alert;
    logic [1:0]        alert_kind;
    logic              caller_protected;
    logic              target_protected;
    status_e           table_status;
  } res_t;

  // table update command from the top level
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [ID_W-1:0] subject_id;
    logic [ID_W-1:0] caller_id;
    logic [ID_W-1:0] target_id;
  } tbl_cmd_t;

  // table search results
  typedef struct packed {
    logic caller_hit;
    logic target_hit;
    logic subject_hit;
    logic has_free;
  } tbl_stat_t;

endpackage

@@ hw/rtl/protected_id_access_filter_unit.sv @@
// ---------------------------------------------------------------------------
// protected_id_access_filter_unit
// Protected identifier table with handle access filtering.
// ---------------------------------------------------------------------------
// The block takes one item per clock cycle while the output is not stalled,
// and returns one result per item. Each item is held in an input register,
// searched combinationally against the 16-entry register table (parallel
// compare of caller, target and subject), and its result lands in an output
// register; the table update for a start or exit event happens at that same
// edge, so the next item already sees it. Configuration registers are written
// through cfg_we_i / cfg_index_i / cfg_data_i; the user must write them only
// while the block is idle, as the block itself does not enforce this.
`include "protected_id_access_filter_unit_assert.svh"

module protected_id_access_filter_unit import pidaf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [MASK_W-1:0]    cfg_data_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  input  logic                 path_match_i,
  input  logic [ID_W-1:0]      subject_id_i,
  input  logic [ID_W-1:0]      caller_id_i,
  input  logic [ID_W-1:0]      target_id_i,
  input  logic                 target_missing_i,
  input  logic                 kernel_handle_i,
  input  logic                 handle_kind_i,
  input  logic [MASK_W-1:0]    desired_access_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [MASK_W-1:0]    granted_access_o,
  output logic                 alert_o,
  output logic [1:0]           alert_kind_o,
  output logic                 caller_protected_o,
  output logic                 target_protected_o,
  output logic [2:0]           table_status_o
);

  cfg_t      cfg_q;
  req_t      req_q;
  res_t      res_q, res;
  logic      in_valid_q, in_valid_d;
  logic      out_valid_q, out_valid_d;
  logic      advance, in_take;
  tbl_cmd_t  tbl_cmd;
  tbl_stat_t tbl_stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.proc_danger <= '0;
      cfg_q.thr_danger  <= '0;
      cfg_q.proc_full   <= FULL_ACCESS_RST;
      cfg_q.thr_full    <= FULL_ACCESS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PROC_DANGER: cfg_q.proc_danger <= cfg_data_i;
        CFG_THR_DANGER:  cfg_q.thr_danger  <= cfg_data_i;
        CFG_PROC_FULL:   cfg_q.proc_full   <= cfg_data_i;
        CFG_THR_FULL:    cfg_q.thr_full    <= cfg_data_i;
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  // handshake control
  assign advance    = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (!in_stall_o) begin
      in_valid_d = in_valid_i;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q.op             <= op_e'(op_i);
      req_q.path_match     <= path_match_i;
      req_q.subject_id     <= subject_id_i;
      req_q.caller_id      <= caller_id_i;
      req_q.target_id      <= target_id_i;
      req_q.target_missing <= target_missing_i;
      req_q.kernel_handle  <= kernel_handle_i;
      req_q.handle_kind    <= handle_kind_i;
      req_q.desired_access <= desired_access_i;
    end
  end

  // table update only when the item moves to the result register
  assign tbl_cmd.ins        = advance && (req_q.op == OP_START) && req_q.path_match;
  assign tbl_cmd.rem        = advance && (req_q.op == OP_EXIT);
  assign tbl_cmd.subject_id = req_q.subject_id;
  assign tbl_cmd.caller_id  = req_q.caller_id;
  assign tbl_cmd.target_id  = req_q.target_id;

  pidaf_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (tbl_cmd),
    .stat_o (tbl_stat)
  );

  pidaf_policy u_policy (
    .req_i  (req_q),
    .stat_i (tbl_stat),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign granted_access_o   = res_q.granted_access;
  assign alert_o            = res_q.alert;
  assign alert_kind_o       = res_q.alert_kind;
  assign caller_protected_o = res_q.caller_protected;
  assign target_protected_o = res_q.target_protected;
  assign table_status_o     = res_q.table_status;

  `PIDAF_ASSERT_NXT(a_advance_fills, advance, out_valid_q)
  `PIDAF_ASSERT(a_alert_prot, out_valid_o && alert_o,
                target_protected_o && !caller_protected_o)
  `PIDAF_ASSERT(a_event_clean, out_valid_o && (table_status_o != ST_NONE),
                (granted_access_o == '0) && (alert_kind_o == 2'd0) && !alert_o)

endmodule

@@ hw/rtl/pidaf_table.sv @@
// ---------------------------------------------------------------------------
// pidaf_table
// Register table of protected identifiers with parallel compare, lowest-free
// insert and lowest-match remove.
// ---------------------------------------------------------------------------
`include "protected_id_access_filter_unit_assert.svh"

module pidaf_table import pidaf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tbl_cmd_t  cmd_i,
  output tbl_stat_t stat_o
);

  logic [TABLE_DEPTH-1:0] slot_valid_q, slot_valid_d;
  logic [ID_W-1:0]        slot_id_q [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] caller_vec, target_vec, subject_vec, free_vec;
  logic [TABLE_DEPTH-1:0] free_oh, subject_oh;

  // parallel compare against every valid slot
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      caller_vec[i]  = slot_valid_q[i] && (slot_id_q[i] == cmd_i.caller_id);
      target_vec[i]  = slot_valid_q[i] && (slot_id_q[i] == cmd_i.target_id);
      subject_vec[i] = slot_valid_q[i] && (slot_id_q[i] == cmd_i.subject_id);
    end
  end

  assign free_vec = ~slot_valid_q;

  // isolate lowest set bit
  assign free_oh    = free_vec & (~free_vec + TABLE_DEPTH'(1));
  assign subject_oh = subject_vec & (~subject_vec + TABLE_DEPTH'(1));

  assign stat_o.caller_hit  = |caller_vec;
  assign stat_o.target_hit  = |target_vec;
  assign stat_o.subject_hit = |subject_vec;
  assign stat_o.has_free    = |free_vec;

  // valid bit update
  always_comb begin
    slot_valid_d = slot_valid_q;
    if (cmd_i.ins) begin
      slot_valid_d = slot_valid_q | free_oh;
    end
    if (cmd_i.rem) begin
      slot_valid_d = slot_valid_q & ~subject_oh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else begin
      slot_valid_q <= slot_valid_d;
    end
  end

  // identifier storage, written into the chosen free slot
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (cmd_i.ins && free_oh[i]) begin
        slot_id_q[i] <= cmd_i.subject_id;
      end
    end
  end

  `PIDAF_ASSERT(a_ins_rem_excl, cmd_i.ins, !cmd_i.rem)
  `PIDAF_ASSERT_NXT(a_ins_grows, cmd_i.ins && stat_o.has_free,
                    $countones(slot_valid_q) == $countones($past(slot_valid_q)) + 1)
  `PIDAF_ASSERT_NXT(a_rem_shrinks, cmd_i.rem && stat_o.subject_hit,
                    $countones(slot_valid_q) + 1 == $countones($past(slot_valid_q)))

endmodule

@@ hw/rtl/pidaf_policy.sv @@
// ---------------------------------------------------------------------------
// pidaf_policy
// Access decision for handle requests and status coding for table events.
// ---------------------------------------------------------------------------
module pidaf_policy import pidaf_pkg::*; (
  input  req_t      req_i,
  input  tbl_stat_t stat_i,
  input  cfg_t      cfg_i,
  output res_t      res_o
);

  logic              is_thread;
  logic              filter;
  logic [MASK_W-1:0] danger;
  logic [MASK_W-1:0] full;
  logic              cp, tp;

  assign is_thread = (req_i.op == OP_THREAD);
  // kernel handles, self access and ownerless threads skip the lookup
  assign filter = !req_i.kernel_handle && !(is_thread && req_i.target_missing) &&
                  (req_i.caller_id != req_i.target_id);
  assign danger = is_thread ? cfg_i.thr_danger : cfg_i.proc_danger;
  assign full   = is_thread ? cfg_i.thr_full : cfg_i.proc_full;
  assign cp     = filter && stat_i.caller_hit;
  assign tp     = filter && stat_i.target_hit;

  always_comb begin
    res_o = '0;
    res_o.table_status = ST_NONE;
    unique case (req_i.op)
      OP_START: begin
        if (req_i.path_match) begin
          res_o.table_status = stat_i.has_free ? ST_INSERTED : ST_FULL;
        end
      end
      OP_EXIT: begin
        res_o.table_status = stat_i.subject_hit ? ST_REMOVED : ST_NOT_FOUND;
      end
      OP_PROC, OP_THREAD: begin
        res_o.alert_kind       = {is_thread, req_i.handle_kind};
        res_o.caller_protected = cp;
        res_o.target_protected = tp;
        res_o.granted_access   = req_i.desired_access;
        // protection decides between full grant, widening and stripping
        if (cp && tp) begin
          res_o.granted_access = full;
        end else if (cp && !tp) begin
          if (is_thread && !req_i.handle_kind) begin
            res_o.granted_access = req_i.desired_access | cfg_i.proc_full;
          end
        end else if (!cp && tp) begin
          if ((req_i.desired_access & danger) != '0) begin
            res_o.granted_access = req_i.desired_access & ~danger;
            res_o.alert          = 1'b1;
          end
        end
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule
